[hdl/vtbs_pkg.sv]
// Shared types and constants for the value to byte serializer.
package vtbs_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QAW     = $clog2(QDEPTH);

    localparam logic [6:0] GROUP_MASK = 7'h7F;
    localparam logic [7:0] CONT_BIT   = 8'h80;

    typedef enum logic [2:0] {
        REQ_FIXED8   = 3'd0,
        REQ_FIXED16  = 3'd1,
        REQ_FIXED32  = 3'd2,
        REQ_FIXED64  = 3'd3,
        REQ_UVAR32   = 3'd4,
        REQ_ZVAR32   = 3'd5,
        REQ_UVAR64   = 3'd6,
        REQ_ZVAR64   = 3'd7
    } t_req_type;

    // One classified item: for varints the data is the value to split into
    // 7-bit groups; for fixed formats it holds the bytes in emission order,
    // first byte in the low byte, and rem is the byte count minus one.
    typedef struct packed {
        logic               varint;
        logic [2:0]         rem;
        logic [VALUE_W-1:0] data;
    } t_entry;

endpackage

[hdl/vtbs_req_if.sv]
// Request channel: format code and value, with valid and ready.
interface vtbs_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [63:0] value_bits;

    modport source (output valid, output req_type, output value_bits, input ready);
    modport sink   (input valid, input req_type, input value_bits, output ready);
endinterface

[hdl/vtbs_byte_if.sv]
// Byte channel: one serialized byte per word, with a last-byte mark.
interface vtbs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

[hdl/vtbs_cfg_if.sv]
// Configuration write channel carrying the byte order register.
interface vtbs_cfg_if;
    logic valid;
    logic ready;
    logic byte_order;

    modport source (output valid, output byte_order, input ready);
    modport sink   (input valid, input byte_order, output ready);
endinterface

[hdl/vtbs_front.sv]
// Front stage: accepts requests and turns them into queue entries.
module vtbs_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_byte_order,
    vtbs_req_if.sink            i_req,
    output logic                o_push,
    output vtbs_pkg::t_entry    o_entry,
    input  logic                i_push_ready
);

    logic             r_valid;
    vtbs_pkg::t_entry r_entry;
    vtbs_pkg::t_entry n_entry;
    logic [31:0]      u32;
    logic [31:0]      z32;
    logic [63:0]      z64;
    logic [63:0]      v;
    logic [2:0]       nb_m1;
    logic             accept;

    assign i_req.ready = !r_valid || i_push_ready;
    assign accept      = i_req.valid && i_req.ready;
    assign o_push      = r_valid;
    assign o_entry     = r_entry;

    assign v   = i_req.value_bits;
    assign u32 = v[31:0];
    assign z32 = {u32[30:0], 1'b0} ^ {32{u32[31]}};
    assign z64 = {v[62:0], 1'b0} ^ {64{v[63]}};

    always_comb begin
        n_entry = '0;
        nb_m1   = 3'd0;
        unique case (vtbs_pkg::t_req_type'(i_req.req_type))
            vtbs_pkg::REQ_FIXED8:  nb_m1 = 3'd0;
            vtbs_pkg::REQ_FIXED16: nb_m1 = 3'd1;
            vtbs_pkg::REQ_FIXED32: nb_m1 = 3'd3;
            vtbs_pkg::REQ_FIXED64: nb_m1 = 3'd7;
            default:               nb_m1 = 3'd0;
        endcase
        unique case (vtbs_pkg::t_req_type'(i_req.req_type))
            vtbs_pkg::REQ_UVAR32: begin
                n_entry.varint = 1'b1;
                n_entry.data   = {32'd0, u32};
            end
            vtbs_pkg::REQ_ZVAR32: begin
                n_entry.varint = 1'b1;
                n_entry.data   = {32'd0, z32};
            end
            vtbs_pkg::REQ_UVAR64: begin
                n_entry.varint = 1'b1;
                n_entry.data   = v;
            end
            vtbs_pkg::REQ_ZVAR64: begin
                n_entry.varint = 1'b1;
                n_entry.data   = z64;
            end
            default: begin
                // Fixed formats: big endian reverses the low bytes so the
                // back end always shifts out from the bottom.
                n_entry.varint = 1'b0;
                n_entry.rem    = nb_m1;
                if (i_byte_order) begin
                    n_entry.data = v;
                end else begin
                    for (int k = 0; k < 8; k++) begin
                        if (k <= int'(nb_m1)) begin
                            n_entry.data[k*8 +: 8] = v[(int'(nb_m1) - k)*8 +: 8];
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= n_entry;
        end
    end

endmodule

[hdl/vtbs_fifo.sv]
// Short first-word-fall-through queue between the front and back stages.
module vtbs_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  vtbs_pkg::t_entry i_entry,
    output logic             o_push_ready,
    output logic             o_valid,
    output vtbs_pkg::t_entry o_entry,
    input  logic             i_pop
);

    vtbs_pkg::t_entry             r_mem [vtbs_pkg::QDEPTH];
    logic [vtbs_pkg::QAW-1:0]     r_wr;
    logic [vtbs_pkg::QAW-1:0]     r_rd;
    logic [vtbs_pkg::QAW:0]       r_cnt;
    logic                         do_push;
    logic                         do_pop;

    assign o_push_ready = (r_cnt != (vtbs_pkg::QAW+1)'(vtbs_pkg::QDEPTH));
    assign o_valid      = (r_cnt != '0);
    assign o_entry      = r_mem[r_rd];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == vtbs_pkg::QAW'(vtbs_pkg::QDEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == vtbs_pkg::QAW'(vtbs_pkg::QDEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

[hdl/vtbs_back.sv]
// Back stage: shifts bytes out of the current entry into the output register.
module vtbs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  vtbs_pkg::t_entry i_q_entry,
    output logic             o_pop,
    vtbs_byte_if.source      o_byte
);

    logic             r_busy;
    vtbs_pkg::t_entry r_work;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    vtbs_pkg::t_entry src;
    vtbs_pkg::t_entry n_work;
    logic             src_valid;
    logic             src_last;
    logic [7:0]       src_byte;
    logic             adv;
    logic             take;

    assign src       = r_busy ? r_work : i_q_entry;
    assign src_valid = r_busy || i_q_valid;
    assign src_last  = src.varint ? (src.data[63:7] == '0) : (src.rem == 3'd0);
    assign src_byte  = src.varint
                     ? ({1'b0, src.data[6:0] & vtbs_pkg::GROUP_MASK}
                        | (src_last ? 8'h00 : vtbs_pkg::CONT_BIT))
                     : src.data[7:0];
    assign adv       = !r_out_valid || o_byte.ready;
    assign take      = adv && src_valid;
    assign o_pop     = take && !r_busy;

    always_comb begin
        n_work        = src;
        n_work.rem    = src.rem - 3'd1;
        n_work.data   = src.varint ? (src.data >> 7) : (src.data >> 8);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_busy <= !src_last;
            end
            if (adv) begin
                r_out_valid <= src_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_work     <= n_work;
            r_out_byte <= src_byte;
            r_out_last <= src_last;
        end
    end

    assign o_byte.valid     = r_out_valid;
    assign o_byte.out_byte  = r_out_byte;
    assign o_byte.last_byte = r_out_last;

endmodule

[hdl/value_to_byte_serializer.sv]
// Top level of the value to byte serializer: fixed-width and varint encoder.
//
// Usage: each word on i_req carries a format code (req_type) and a 64-bit
// value. Fixed formats of 8, 16, 32 or 64 bits emit the low 1, 2, 4 or 8
// bytes, in the order set by the byte order register. Varint formats emit
// 7-bit groups least significant first with the continuation bit set on all
// but the last byte; the zigzag formats map signed values first.
// Each word on o_byte is one serialized byte, with last_byte high on the
// final byte of a value. The i_cfg channel writes the byte order register
// (0 big endian, 1 little endian) and is always ready; write it only while
// the block is idle.
// Path: a request is registered in the front stage, written into the queue,
// and its first byte goes through the back stage's output register.
// Throughput: one byte per cycle on o_byte while o_byte.ready is high; the
// byte shifter in the back stage sets this rate. A value has 1 to 10 bytes.
// Requests are accepted in consecutive cycles until the four-entry queue
// between the front and back stages fills.
// Reset: front and queue empty, no output pending, byte order big endian.
// Stall: when o_byte.ready is low the current byte holds, the back stage
// waits, and the queue absorbs requests before i_req.ready drops.
module value_to_byte_serializer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vtbs_req_if.sink    i_req,
    vtbs_cfg_if.sink    i_cfg,
    vtbs_byte_if.source o_byte
);

    logic             r_byte_order;
    logic             f_push;
    vtbs_pkg::t_entry f_entry;
    logic             q_push_ready;
    logic             q_valid;
    vtbs_pkg::t_entry q_entry;
    logic             b_pop;

    // User changes the register only while idle, unenforced; front reads it.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_order <= 1'b0;
        end else if (i_cfg.valid) begin
            r_byte_order <= i_cfg.byte_order;
        end
    end

    // Front stage classifies the request and prepares the bytes.
    vtbs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_order (r_byte_order),
        .i_req        (i_req),
        .o_push       (f_push),
        .o_entry      (f_entry),
        .i_push_ready (q_push_ready)
    );

    // The queue decouples request acceptance from byte emission.
    vtbs_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (f_push),
        .i_entry      (f_entry),
        .o_push_ready (q_push_ready),
        .o_valid      (q_valid),
        .o_entry      (q_entry),
        .i_pop        (b_pop)
    );

    // Back stage registers one byte per cycle onto o_byte unless stalled.
    vtbs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_pop     (b_pop),
        .o_byte    (o_byte)
    );

endmodule

[hdl/vtbs_checker.sv]
// Port-level checker for the value to byte serializer, bound to the top level.
module vtbs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    logic [3:0] r_open;
    logic       in_acc;
    logic       out_done;

    assign in_acc   = i_req_valid && i_req_ready;
    assign out_done = i_out_valid && i_out_ready && i_out_last;

    // Values accepted whose last byte has not yet been delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else if (in_acc && !out_done) begin
            r_open <= r_open + 1'b1;
        end else if (out_done && !in_acc) begin
            r_open <= r_open - 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
        && $stable(i_out_last))
        else $error("output word changed while stalled");

    a_no_orphan_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_open != 4'd0)
        else $error("output byte with no value outstanding");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= 4'd7)
        else $error("more values in flight than the stages can hold");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open == 4'd0 |-> i_req_ready)
        else $error("request stalled while block empty");

endmodule

bind value_to_byte_serializer vtbs_checker u_vtbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_out_valid (o_byte.valid),
    .i_out_ready (o_byte.ready),
    .i_out_byte  (o_byte.out_byte),
    .i_out_last  (o_byte.last_byte)
);

[dv/value_to_byte_serializer_tb.sv]
`timescale 1ns / 100ps
// Testbench for the value to byte serializer: directed and random values, checked byte by byte.
module value_to_byte_serializer_tb;

    // The run is short: about 130 values of at most ten bytes each, with random
    // gaps and stalls. The limit leaves a wide margin.
    localparam int CYCLE_LIMIT  = 200000;
    // A request passes the front register, the queue and the output register
    // before its first byte leaves, so this margin makes sure nothing else comes.
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;

    // One expected word on the byte channel.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_ser_byte;

    logic i_clk;
    logic i_rst_n;

    vtbs_req_if  req_if ();
    vtbs_cfg_if  cfg_if ();
    vtbs_byte_if byte_if ();

    value_to_byte_serializer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_byte  (byte_if)
    );

    // The bytes that the block still owes, oldest first.
    t_ser_byte expected_bytes[$];
    // The testbench's own copy of the byte order register.
    logic      order_le;
    // Largest random gap or stall; set to zero for stretches at full rate.
    int        max_gap;
    int        mismatches;
    int        cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog. If the run hangs, the counter runs out and the run fails.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Appends one expected byte at the tail of the queue.
    function automatic void queue_byte(input logic [7:0] b, input logic mark);
        t_ser_byte item;
        item.data      = b;
        item.last      = mark;
        expected_bytes = {expected_bytes, item};
    endfunction

    // Works out the serialized bytes of one value and queues them. Fixed
    // formats take the low bytes of the value in the order that the byte
    // order register gives. Varint formats cut the value, zigzag mapped
    // for the signed ones, into 7-bit groups, low group first, with the
    // continuation bit on every byte but the last.
    function automatic void encode_value(input vtbs_pkg::t_req_type kind,
                                         input logic [63:0] v);
        logic [63:0] u;
        int          nbytes;
        int          n;
        int          idx;
        nbytes = 0;
        u      = '0;
        case (kind)
            vtbs_pkg::REQ_FIXED8:  nbytes = 1;
            vtbs_pkg::REQ_FIXED16: nbytes = 2;
            vtbs_pkg::REQ_FIXED32: nbytes = 4;
            vtbs_pkg::REQ_FIXED64: nbytes = 8;
            vtbs_pkg::REQ_UVAR32:  u = {32'd0, v[31:0]};
            vtbs_pkg::REQ_ZVAR32:  u = {32'd0, {v[30:0], 1'b0} ^ {32{v[31]}}};
            vtbs_pkg::REQ_UVAR64:  u = v;
            default:               u = {v[62:0], 1'b0} ^ {64{v[63]}};
        endcase
        if (nbytes > 0) begin
            for (int k = 0; k < nbytes; k++) begin
                idx = order_le ? k : (nbytes - 1 - k);
                queue_byte(v[idx*8 +: 8], (k == nbytes - 1));
            end
        end else begin
            // A 64-bit value has at most one bit left after nine groups,
            // so the tenth byte never needs the continuation bit.
            n = 0;
            while (u >= 64'h80 && n < 9) begin
                queue_byte({1'b1, u[6:0]}, 1'b0);
                u = u >> 7;
                n++;
            end
            queue_byte(u[7:0], 1'b1);
        end
    endfunction

    // Byte checker. Every accepted word is compared with the oldest
    // expected byte; a word with nothing expected is a failure too.
    always @(posedge i_clk) begin
        t_ser_byte want;
        if (i_rst_n && byte_if.valid && byte_if.ready) begin
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected word: byte %02h last %0b",
                             byte_if.out_byte, byte_if.last_byte);
                end
            end else begin
                want = expected_bytes.pop_front();
                if (byte_if.out_byte !== want.data || byte_if.last_byte !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                                 want.data, want.last, byte_if.out_byte, byte_if.last_byte);
                    end
                end
            end
        end
    end

    // Byte sink. Before each word it holds ready low for a random number
    // of cycles, then keeps it high until a word is taken. Ready changes
    // only at falling edges, and only once per edge.
    initial begin
        int stall;
        byte_if.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = $urandom_range(0, max_gap);
            if (stall > 0) begin
                byte_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            byte_if.ready <= 1'b1;
            do @(posedge i_clk); while (!byte_if.valid);
            @(negedge i_clk);
        end
    end

    // Sends one value. It is entered at a falling edge and returns at the
    // falling edge after the word was taken, with valid still high, so the
    // next call can keep valid high for a back-to-back word.
    task automatic send_value(input vtbs_pkg::t_req_type kind, input logic [63:0] v);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.req_type   <= kind;
        req_if.value_bits <= v;
        do @(posedge i_clk); while (!req_if.ready);
        encode_value(kind, v);
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every expected byte has come out, then
    // waits out the drain margin so that the block is surely idle.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (expected_bytes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Writes the byte order register once the block is idle.
    task automatic write_order(input logic le);
        wait_drained();
        cfg_if.valid      <= 1'b1;
        cfg_if.byte_order <= le;
        do @(posedge i_clk); while (!cfg_if.ready);
        order_le = le;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Nothing is written here, so a 64-bit value must come out big endian.
    task automatic test_reset_order();
        send_value(vtbs_pkg::REQ_FIXED64, 64'h0102_0304_0506_0708);
    endtask

    // Fixed formats at both byte orders, with the unused high bits set so
    // that they must be ignored. Fixed8 gives one byte in either order.
    task automatic test_fixed_formats();
        write_order(1'b1);
        send_value(vtbs_pkg::REQ_FIXED8,  64'hFFFF_FFFF_FFFF_FFA5);
        send_value(vtbs_pkg::REQ_FIXED16, 64'hDEAD_BEEF_CAFE_A55A);
        send_value(vtbs_pkg::REQ_FIXED32, 64'hFFFF_FFFF_8001_02FF);
        send_value(vtbs_pkg::REQ_FIXED64, 64'hFFFF_FFFF_FFFF_FFFF);
        send_value(vtbs_pkg::REQ_FIXED64, 64'h0000_0000_0000_0000);
        write_order(1'b0);
        send_value(vtbs_pkg::REQ_FIXED8,  64'h1234_5678_9ABC_DE00);
        send_value(vtbs_pkg::REQ_FIXED16, 64'hFFFF_FFFF_FFFF_00FF);
        send_value(vtbs_pkg::REQ_FIXED32, 64'h5555_5555_AABB_CCDD);
    endtask

    // Varint formats: zero as a single byte, the first group boundary, the
    // largest values and the signed extremes for the zigzag formats.
    task automatic test_varint_formats();
        send_value(vtbs_pkg::REQ_UVAR32, 64'h0000_0000_0000_0000);
        send_value(vtbs_pkg::REQ_UVAR32, 64'h0000_0000_0000_007F);
        send_value(vtbs_pkg::REQ_UVAR32, 64'hFFFF_FFFF_0000_0080);
        send_value(vtbs_pkg::REQ_UVAR32, 64'hFFFF_FFFF_FFFF_FFFF);
        send_value(vtbs_pkg::REQ_ZVAR32, 64'hABCD_0000_0000_0000);
        send_value(vtbs_pkg::REQ_ZVAR32, 64'h0000_0000_FFFF_FFFF);
        send_value(vtbs_pkg::REQ_ZVAR32, 64'h0000_0000_7FFF_FFFF);
        send_value(vtbs_pkg::REQ_ZVAR32, 64'h0000_0000_8000_0000);
        send_value(vtbs_pkg::REQ_UVAR64, 64'h0000_0000_0000_0000);
        send_value(vtbs_pkg::REQ_UVAR64, 64'hFFFF_FFFF_FFFF_FFFF);
        send_value(vtbs_pkg::REQ_UVAR64, 64'h8000_0000_0000_0000);
        send_value(vtbs_pkg::REQ_ZVAR64, 64'hFFFF_FFFF_FFFF_FFFF);
        send_value(vtbs_pkg::REQ_ZVAR64, 64'h8000_0000_0000_0000);
        send_value(vtbs_pkg::REQ_ZVAR64, 64'h7FFF_FFFF_FFFF_FFFF);
    endtask

    // Random values spread over all varint lengths: full-width random bits,
    // small positive and negative values, and low words under an all-zero or all-one high word.
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int          shift;
        v     = {$urandom, $urandom};
        shift = $urandom_range(0, 63);
        case ($urandom_range(0, 3))
            0:       random_value = v;
            1:       random_value = v >> shift;
            2:       random_value = ~(v >> shift);
            default: random_value = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0,
                                     v[31:0] >> (shift % 32)};
        endcase
    endfunction

    // Random formats and values in four phases that switch the byte order.
    // The third phase runs with no gaps and no stalls so that the queue
    // fills and requests go in back to back.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            write_order(phase[0]);
            max_gap = (phase == 2) ? 0 : 10;
            for (int i = 0; i < 27; i++) begin
                send_value(vtbs_pkg::t_req_type'($urandom_range(0, 7)), random_value());
            end
        end
        max_gap = 10;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.req_type   = vtbs_pkg::REQ_FIXED8;
        req_if.value_bits = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.byte_order = 1'b0;
        order_le          = 1'b0;
        max_gap           = 10;
        mismatches        = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_order();
        test_fixed_formats();
        test_varint_formats();
        test_random_traffic();

        wait_drained();
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
